FILE: rtl/core/trpc_pkg.sv
package trpc_pkg;

	localparam int unsigned PIX_W     = 16;
	localparam int unsigned IDX_W     = 18;
	localparam int unsigned PRIME_W   = 8;
	localparam int unsigned ROW_WIDTH = 512;
	localparam int unsigned OFS_W     = 10;
	localparam int unsigned DVD_W     = 32;
	localparam int unsigned DVS_W     = 16;
	localparam int unsigned ACC_W     = 24;
	localparam int unsigned TRIAL_W   = 9;

	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_BAD_PRIME = 2'd1;
	localparam logic [1:0] STS_NO_KEY    = 2'd2;

	localparam logic CFG_PRIME_ONE = 1'b0;
	localparam logic CFG_PRIME_TWO = 1'b1;

	localparam logic OP_ENC = 1'b0;

	typedef enum logic [4:0] {
		S_IDLE,
		S_KEY_P,
		S_KEY_Q,
		S_PT_INIT,
		S_PT_CHK,
		S_PT_WAIT,
		S_PT_RET,
		S_KEY_NT,
		S_E_CHK,
		S_E_WAIT,
		S_D_ADD,
		S_D_GO,
		S_D_WAIT,
		S_KEY_END,
		S_ITEM,
		S_BASE_WAIT,
		S_EXP,
		S_MUL_WAIT,
		S_SQR,
		S_SQR_WAIT,
		S_OUT
	} state_t;

	typedef enum logic [1:0] {
		PT_P,
		PT_Q,
		PT_E
	} ptsel_t;

	typedef struct packed {
		logic             start;
		logic [DVD_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DVD_W-1:0] quot;
		logic [DVS_W-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic             valid;
		logic [PIX_W-1:0] value;
		logic [1:0]       status;
	} res_t;

endpackage

FILE: rtl/core/trpc_if.sv
interface trpc_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [15:0] pixel_value;
	logic [17:0] pixel_index;

	modport source (output valid, opcode, pixel_value, pixel_index, input ready);
	modport sink (input valid, opcode, pixel_value, pixel_index, output ready);
endinterface

interface trpc_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] result_value;
	logic [1:0]  status;

	modport source (output valid, result_value, status, input ready);
	modport sink (input valid, result_value, status, output ready);
endinterface

FILE: rtl/core/trpc_div.sv
// restoring divider, one quotient bit per cycle; quotient shifts into the dividend register
module trpc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  trpc_pkg::div_req_t  req,
	output trpc_pkg::div_rsp_t  rsp
);

	localparam int unsigned CNT_W = $clog2(trpc_pkg::DVD_W);

	logic                        busy_q;
	logic                        done_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [trpc_pkg::DVD_W-1:0]  dvd_q;
	logic [trpc_pkg::DVS_W-1:0]  dvs_q;
	logic [trpc_pkg::DVS_W-1:0]  rem_q;
	logic [trpc_pkg::DVS_W:0]    trial;
	logic                        fits;

	assign trial = {rem_q, dvd_q[trpc_pkg::DVD_W-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(trpc_pkg::DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[trpc_pkg::DVD_W-2:0], fits};
			rem_q <= fits ? trpc_pkg::DVS_W'(trial - {1'b0, dvs_q})
			              : trial[trpc_pkg::DVS_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = dvd_q;
	assign rsp.rem  = rem_q;

endmodule

FILE: rtl/core/trpc_ctrl.sv
// sequencer: derives the key pair once per configuration, then square-and-multiply
module trpc_ctrl (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [trpc_pkg::PRIME_W-1:0]      prime_one,
	input  logic [trpc_pkg::PRIME_W-1:0]      prime_two,
	trpc_in_if.sink                           in_ch,
	input  logic                              out_free,
	output trpc_pkg::res_t                    res,
	output trpc_pkg::div_req_t                div_req,
	input  trpc_pkg::div_rsp_t                div_rsp
);

	trpc_pkg::state_t state_q, state_d;
	trpc_pkg::ptsel_t ptsel_q;

	logic                          keys_valid_q;
	logic [1:0]                    status_q;
	logic [trpc_pkg::DVS_W-1:0]    n_q, t_q, e_q, d_q, cand_q, ptv_q;
	logic [trpc_pkg::TRIAL_W-1:0]  trial_q;
	logic                          pass_q;
	logic [trpc_pkg::ACC_W-1:0]    acc_q;
	logic                          op_q;
	logic [trpc_pkg::PIX_W-1:0]    r_q, base_q, expo_q;
	logic [trpc_pkg::OFS_W-1:0]    ofs_q;

	logic [2*trpc_pkg::TRIAL_W-1:0] trial_sq;
	logic                           accept;
	logic [trpc_pkg::OFS_W-1:0]     ofs_in;

	assign trial_sq = {{trpc_pkg::TRIAL_W{1'b0}}, trial_q}
	                * {{trpc_pkg::TRIAL_W{1'b0}}, trial_q};
	assign accept   = in_ch.valid && in_ch.ready;
	assign ofs_in   = trpc_pkg::OFS_W'(in_ch.pixel_index / trpc_pkg::ROW_WIDTH)
	                + trpc_pkg::OFS_W'(in_ch.pixel_index % trpc_pkg::ROW_WIDTH);

	always_comb begin
		state_d = state_q;
		case (state_q)
			trpc_pkg::S_IDLE:
				if (in_ch.valid) state_d = keys_valid_q ? trpc_pkg::S_ITEM : trpc_pkg::S_KEY_P;
			trpc_pkg::S_KEY_P:   state_d = trpc_pkg::S_PT_INIT;
			trpc_pkg::S_KEY_Q:   state_d = trpc_pkg::S_PT_INIT;
			trpc_pkg::S_PT_INIT:
				state_d = (ptv_q < 16'd2) ? trpc_pkg::S_PT_RET : trpc_pkg::S_PT_CHK;
			trpc_pkg::S_PT_CHK:
				state_d = ({2'b0, trial_sq} > ptv_q) ? trpc_pkg::S_PT_RET
				                                     : trpc_pkg::S_PT_WAIT;
			trpc_pkg::S_PT_WAIT: begin
				if (div_rsp.done)
					state_d = (div_rsp.rem == '0) ? trpc_pkg::S_PT_RET : trpc_pkg::S_PT_CHK;
			end
			trpc_pkg::S_PT_RET: begin
				case (ptsel_q)
					trpc_pkg::PT_P: state_d = pass_q ? trpc_pkg::S_KEY_Q : trpc_pkg::S_KEY_END;
					trpc_pkg::PT_Q: state_d = pass_q ? trpc_pkg::S_KEY_NT : trpc_pkg::S_KEY_END;
					default:        state_d = pass_q ? trpc_pkg::S_D_ADD : trpc_pkg::S_E_CHK;
				endcase
			end
			trpc_pkg::S_KEY_NT:  state_d = trpc_pkg::S_E_CHK;
			trpc_pkg::S_E_CHK:
				state_d = (cand_q >= t_q) ? trpc_pkg::S_KEY_END : trpc_pkg::S_E_WAIT;
			trpc_pkg::S_E_WAIT: begin
				if (div_rsp.done) begin
					if (div_rsp.rem == '0 || cand_q == {8'd0, prime_one}
					    || cand_q == {8'd0, prime_two})
						state_d = trpc_pkg::S_E_CHK;
					else
						state_d = trpc_pkg::S_PT_INIT;
				end
			end
			trpc_pkg::S_D_ADD:   state_d = trpc_pkg::S_D_GO;
			trpc_pkg::S_D_GO:    state_d = trpc_pkg::S_D_WAIT;
			trpc_pkg::S_D_WAIT: begin
				if (div_rsp.done)
					state_d = (div_rsp.rem == '0) ? trpc_pkg::S_KEY_END : trpc_pkg::S_D_ADD;
			end
			trpc_pkg::S_KEY_END: state_d = trpc_pkg::S_ITEM;
			trpc_pkg::S_ITEM:
				state_d = (status_q != trpc_pkg::STS_OK) ? trpc_pkg::S_OUT
				                                         : trpc_pkg::S_BASE_WAIT;
			trpc_pkg::S_BASE_WAIT: if (div_rsp.done) state_d = trpc_pkg::S_EXP;
			trpc_pkg::S_EXP: begin
				if (expo_q == '0)  state_d = trpc_pkg::S_OUT;
				else if (expo_q[0]) state_d = trpc_pkg::S_MUL_WAIT;
				else                state_d = trpc_pkg::S_SQR;
			end
			trpc_pkg::S_MUL_WAIT: if (div_rsp.done) state_d = trpc_pkg::S_SQR;
			trpc_pkg::S_SQR:      state_d = trpc_pkg::S_SQR_WAIT;
			trpc_pkg::S_SQR_WAIT: if (div_rsp.done) state_d = trpc_pkg::S_EXP;
			trpc_pkg::S_OUT:      if (out_free) state_d = trpc_pkg::S_IDLE;
			default:              state_d = trpc_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		in_ch.ready      = state_q == trpc_pkg::S_IDLE;
		div_req.start    = 1'b0;
		div_req.dividend = '0;
		div_req.divisor  = n_q;
		res.valid        = 1'b0;
		res.status       = status_q;
		if (status_q != trpc_pkg::STS_OK)
			res.value = '0;
		else if (op_q == trpc_pkg::OP_ENC)
			res.value = r_q;
		else
			res.value = r_q - {6'd0, ofs_q};
		case (state_q)
			trpc_pkg::S_PT_CHK: begin
				div_req.start    = !({2'b0, trial_sq} > ptv_q);
				div_req.dividend = {16'd0, ptv_q};
				div_req.divisor  = {7'd0, trial_q};
			end
			trpc_pkg::S_E_CHK: begin
				div_req.start    = cand_q < t_q;
				div_req.dividend = {16'd0, t_q};
				div_req.divisor  = cand_q;
			end
			trpc_pkg::S_D_GO: begin
				div_req.start    = 1'b1;
				div_req.dividend = {8'd0, acc_q};
				div_req.divisor  = cand_q;
			end
			trpc_pkg::S_ITEM: begin
				div_req.start    = status_q == trpc_pkg::STS_OK;
				div_req.dividend = {16'd0, base_q};
			end
			trpc_pkg::S_EXP: begin
				div_req.start    = expo_q[0];
				div_req.dividend = trpc_pkg::DVD_W'(r_q) * trpc_pkg::DVD_W'(base_q);
			end
			trpc_pkg::S_SQR: begin
				div_req.start    = 1'b1;
				div_req.dividend = trpc_pkg::DVD_W'(base_q) * trpc_pkg::DVD_W'(base_q);
			end
			trpc_pkg::S_OUT: res.valid = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= trpc_pkg::S_IDLE;
			keys_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we)
				keys_valid_q <= 1'b0;
			else if (state_q == trpc_pkg::S_KEY_END)
				keys_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= in_ch.opcode;
			ofs_q  <= ofs_in;
			base_q <= (in_ch.opcode == trpc_pkg::OP_ENC)
			          ? in_ch.pixel_value + {6'd0, ofs_in} : in_ch.pixel_value;
		end
		case (state_q)
			trpc_pkg::S_KEY_P: begin
				status_q <= trpc_pkg::STS_BAD_PRIME;
				n_q      <= '0;
				ptv_q    <= {8'd0, prime_one};
				ptsel_q  <= trpc_pkg::PT_P;
			end
			trpc_pkg::S_KEY_Q: begin
				ptv_q   <= {8'd0, prime_two};
				ptsel_q <= trpc_pkg::PT_Q;
			end
			trpc_pkg::S_PT_INIT: begin
				trial_q <= trpc_pkg::TRIAL_W'(2);
				pass_q  <= 1'b0;
			end
			trpc_pkg::S_PT_CHK:
				if ({2'b0, trial_sq} > ptv_q) pass_q <= 1'b1;
			trpc_pkg::S_PT_WAIT:
				if (div_rsp.done) trial_q <= trial_q + 1'b1;
			trpc_pkg::S_PT_RET: begin
				acc_q <= trpc_pkg::ACC_W'(1);
				if (ptsel_q == trpc_pkg::PT_E && !pass_q) cand_q <= cand_q + 1'b1;
			end
			trpc_pkg::S_KEY_NT: begin
				n_q      <= trpc_pkg::DVS_W'(prime_one) * trpc_pkg::DVS_W'(prime_two);
				t_q      <= trpc_pkg::DVS_W'(prime_one - 1'b1)
				          * trpc_pkg::DVS_W'(prime_two - 1'b1);
				cand_q   <= 16'd2;
				status_q <= trpc_pkg::STS_NO_KEY;
			end
			trpc_pkg::S_E_WAIT: begin
				if (div_rsp.done) begin
					if (div_rsp.rem == '0 || cand_q == {8'd0, prime_one}
					    || cand_q == {8'd0, prime_two}) begin
						cand_q <= cand_q + 1'b1;
					end else begin
						ptv_q   <= cand_q;
						ptsel_q <= trpc_pkg::PT_E;
					end
				end
			end
			trpc_pkg::S_D_ADD: acc_q <= acc_q + {8'd0, t_q};
			trpc_pkg::S_D_WAIT: begin
				if (div_rsp.done && div_rsp.rem == '0) begin
					e_q      <= cand_q;
					d_q      <= div_rsp.quot[trpc_pkg::DVS_W-1:0];
					status_q <= trpc_pkg::STS_OK;
				end
			end
			trpc_pkg::S_BASE_WAIT: begin
				if (div_rsp.done) begin
					base_q <= div_rsp.rem;
					r_q    <= 16'd1;
					expo_q <= (op_q == trpc_pkg::OP_ENC) ? e_q : d_q;
				end
			end
			trpc_pkg::S_MUL_WAIT:
				if (div_rsp.done) r_q <= div_rsp.rem;
			trpc_pkg::S_SQR_WAIT: begin
				if (div_rsp.done) begin
					base_q <= div_rsp.rem;
					expo_q <= expo_q >> 1;
				end
			end
			default: ;
		endcase
	end

endmodule

FILE: rtl/core/toy_rsa_pixel_cipher.sv
// Path from accept to out_ch.valid: reducing the base, then per exponent bit a squaring and
// per set bit a multiply, each modular step being one pass of the shared 32-bit serial divider.
// Encrypt uses the small e; decrypt uses a 16-bit d.
// After a prime is written, the next word first rederives the key pair on the same divider,
// stopping early on a bad prime. One word at a time.
// Reset clears both primes to zero (status 1 until valid primes are written).
module toy_rsa_pixel_cipher (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic                          cfg_index,
	input  logic [trpc_pkg::PRIME_W-1:0]  cfg_data,
	trpc_in_if.sink                       in_ch,
	trpc_out_if.source                    out_ch
);

	logic [trpc_pkg::PRIME_W-1:0] prime_one_q, prime_two_q;
	logic                         out_valid_q;
	logic [trpc_pkg::PIX_W-1:0]   out_value_q;
	logic [1:0]                   out_status_q;
	logic                         out_free;

	trpc_pkg::res_t     res;
	trpc_pkg::div_req_t div_req;
	trpc_pkg::div_rsp_t div_rsp;

	assign out_free = !out_valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prime_one_q <= '0;
			prime_two_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == trpc_pkg::CFG_PRIME_ONE) prime_one_q <= cfg_data;
			if (cfg_we && cfg_index == trpc_pkg::CFG_PRIME_TWO) prime_two_q <= cfg_data;
			if (res.valid)
				out_valid_q <= 1'b1;
			else if (out_ch.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_value_q  <= res.value;
			out_status_q <= res.status;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.result_value = out_value_q;
	assign out_ch.status       = out_status_q;

	trpc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.prime_one (prime_one_q),
		.prime_two (prime_two_q),
		.in_ch     (in_ch),
		.out_free  (out_free),
		.res       (res),
		.div_req   (div_req),
		.div_rsp   (div_rsp)
	);

	trpc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule
